@@ rtl/rfrc_pkg.sv @@
// Package for the row first-run centroid block.
// Holds the controller state, the run phase, the command struct and the fixed field widths.
`timescale 1ns / 1ps

package rfrc_pkg;

    localparam int PIXEL_W    = 8;
    localparam int ROW_INDEX_W = 11;
    localparam int CENTROID_W = 19;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_IN     = 2'd1,
        PH_AFTER  = 2'd2
    } t_phase;

    typedef struct packed {
        logic px_take;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

@@ rtl/row_first_run_centroid.sv @@
// Top level of the row first-run centroid block.
// Depends on rfrc_pkg, rfrc_ctrl and rfrc_dpath.
`timescale 1ns / 1ps

// Pixels are taken one word per clock in raster order while no row end is stalled.
// The mean column of the first foreground run of each row is worked out by a
// restoring divider that produces one quotient bit per cycle; when the divide is done,
// the result is moved into the output register once that is free. Pixels of the next
// row keep flowing meanwhile. The divider is the single shared unit: a row end that
// arrives while it is busy dividing or holding a finished result is stalled. A finished
// word waits in the output register while the next row is accumulated.
module row_first_run_centroid
    import rfrc_pkg::*;
#(
    parameter int MAX_COLS  = 2048,
    parameter int MAX_ROWS  = 2048,
    parameter int FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PIXEL_W-1:0]     i_pixel,
    input  logic                   i_row_end,
    input  logic                   i_frame_start,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ROW_INDEX_W-1:0] o_row_index,
    output logic [CENTROID_W-1:0]  o_centroid
);

    localparam int SUM_MAX = MAX_COLS * (MAX_COLS - 1) / 2;
    localparam int SUM_W   = (SUM_MAX > 0) ? $clog2(SUM_MAX + 1) : 1;
    localparam int NUM_W   = SUM_W + FRAC_BITS;

    t_cmd cmd;

    rfrc_ctrl #(
        .NUM_W (NUM_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_row_end (i_row_end),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (cmd)
    );

    rfrc_dpath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pixel       (i_pixel),
        .i_row_end     (i_row_end),
        .i_frame_start (i_frame_start),
        .o_row_index   (o_row_index),
        .o_centroid    (o_centroid)
    );

endmodule

@@ rtl/rfrc_ctrl.sv @@
// Controller of the row first-run centroid block: divider sequencing and handshakes.
// Depends on rfrc_pkg; drives the command struct of rfrc_dpath.
`timescale 1ns / 1ps

module rfrc_ctrl
    import rfrc_pkg::*;
#(
    parameter int NUM_W = 29
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_row_end,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               px_take;
    logic               cnt_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // A word that closes a row needs the divider, so it waits until the divider is idle.
    assign o_stall  = i_row_end && (r_state != ST_IDLE);
    assign px_take  = i_valid && !o_stall;
    assign cnt_last = (r_cnt == CNT_W'(NUM_W - 1));
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.px_take = px_take;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (px_take && i_row_end) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (cnt_last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_row_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_row_end) |=> (r_state == ST_DIV))
        else $error("accepted row end did not start a divide");

    a_div_ends_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && cnt_last) |=> (r_state == ST_HOLD))
        else $error("divide did not finish after the last step");

    a_hold_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && !(r_out_valid && i_stall)) |=> (o_valid && r_state == ST_IDLE))
        else $error("finished quotient was not moved to the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("output register loaded while a stalled word waits");

endmodule

@@ rtl/rfrc_dpath.sv @@
// Datapath of the row first-run centroid block: run accumulation, restoring divider, output.
// Depends on rfrc_pkg; sequenced by rfrc_ctrl through the command struct.
`timescale 1ns / 1ps

module rfrc_dpath
    import rfrc_pkg::*;
#(
    parameter int MAX_COLS  = 2048,
    parameter int MAX_ROWS  = 2048,
    parameter int FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [PIXEL_W-1:0]     i_pixel,
    input  logic                   i_row_end,
    input  logic                   i_frame_start,
    output logic [ROW_INDEX_W-1:0] o_row_index,
    output logic [CENTROID_W-1:0]  o_centroid
);

    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LEN_W     = $clog2(MAX_COLS + 1);
    localparam int SUM_MAX   = MAX_COLS * (MAX_COLS - 1) / 2;
    localparam int SUM_W     = (SUM_MAX > 0) ? $clog2(SUM_MAX + 1) : 1;
    localparam int NUM_W     = SUM_W + FRAC_BITS;
    localparam int QEXT_W    = (NUM_W > CENTROID_W) ? NUM_W : CENTROID_W;
    localparam int REXT_W    = (ROW_W > ROW_INDEX_W) ? ROW_W : ROW_INDEX_W;

    logic [COL_W-1:0]       r_col, n_col;
    logic [ROW_W-1:0]       r_row, n_row;
    t_phase                 r_phase, n_phase;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [LEN_W-1:0]       r_len, n_len;

    logic [LEN_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_quo;
    logic [LEN_W-1:0]       r_den;
    logic [ROW_INDEX_W-1:0] r_drow;
    logic [ROW_INDEX_W-1:0] r_out_row;
    logic [CENTROID_W-1:0]  r_out_cen;

    logic [COL_W-1:0]       base_col;
    logic [ROW_W-1:0]       base_row;
    t_phase                 base_phase;
    logic [SUM_W-1:0]       base_sum;
    logic [LEN_W-1:0]       base_len;
    logic                   fg;
    logic                   take_px;

    logic [LEN_W:0]         trial;
    logic [LEN_W:0]         diff;
    logic                   ge;
    logic [QEXT_W-1:0]      quo_ext;
    logic [REXT_W-1:0]      row_ext;

    assign fg = (i_pixel != '0);

    // Frame start clears the row state before the word itself is counted.
    always_comb begin
        base_col   = i_frame_start ? '0 : r_col;
        base_row   = i_frame_start ? '0 : r_row;
        base_phase = i_frame_start ? PH_BEFORE : r_phase;
        base_sum   = i_frame_start ? '0 : r_sum;
        base_len   = i_frame_start ? '0 : r_len;

        take_px = 1'b0;
        n_phase = base_phase;
        case (base_phase)
            PH_BEFORE: begin
                if (fg) begin
                    n_phase = PH_IN;
                    take_px = 1'b1;
                end
            end
            PH_IN: begin
                if (fg) begin
                    take_px = 1'b1;
                end else begin
                    n_phase = PH_AFTER;
                end
            end
            default: begin
                n_phase = base_phase;
            end
        endcase
        n_sum = take_px ? (base_sum + SUM_W'(base_col)) : base_sum;
        n_len = take_px ? (base_len + LEN_W'(1)) : base_len;
        n_row = base_row;
        n_col = base_col;

        if (i_row_end) begin
            n_col = '0;
            if (base_row >= ROW_W'(MAX_ROWS - 1)) begin
                n_row = '0;
            end else begin
                n_row = base_row + ROW_W'(1);
            end
        end else if (base_col >= COL_W'(MAX_COLS - 1)) begin
            // An over-long row stops counting and ignores the rest until its end.
            n_col   = COL_W'(MAX_COLS - 1);
            n_phase = PH_AFTER;
        end else begin
            n_col = base_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= PH_BEFORE;
            r_sum   <= '0;
            r_len   <= '0;
        end else if (i_cmd.px_take) begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_row_end) begin
                r_phase <= PH_BEFORE;
                r_sum   <= '0;
                r_len   <= '0;
            end else begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_len   <= n_len;
            end
        end
    end

    // Restoring division, one quotient bit a cycle, most significant first.
    assign trial   = {r_rem, r_quo[NUM_W-1]};
    assign diff    = trial - {1'b0, r_den};
    assign ge      = (trial >= {1'b0, r_den});
    assign row_ext = REXT_W'(base_row);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= '0;
            r_quo  <= NUM_W'(n_sum) << FRAC_BITS;
            r_den  <= n_len;
            r_drow <= row_ext[ROW_INDEX_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_quo <= (r_quo << 1) | NUM_W'(ge);
        end
    end

    assign quo_ext = QEXT_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row <= r_drow;
            // An empty run divides by zero; it is reported as zero.
            r_out_cen <= (r_den == '0) ? '0 : quo_ext[CENTROID_W-1:0];
        end
    end

    assign o_row_index = r_out_row;
    assign o_centroid  = r_out_cen;

endmodule

@@ tb/row_centroid_checker.sv @@
// Checker for the row first-run centroid block: follows the pixel and result channels.
// It predicts each row's centroid and compares it with what the block reports.
// Depends on rfrc_pkg.
`timescale 1ns / 1ps

module row_centroid_checker
    import rfrc_pkg::*;
#(
    parameter int MAX_COLS  = 2048,
    parameter int MAX_ROWS  = 2048,
    parameter int FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_px_valid,
    input  logic                   i_px_stall,
    input  logic [PIXEL_W-1:0]     i_pixel,
    input  logic                   i_row_end,
    input  logic                   i_frame_start,
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  logic [ROW_INDEX_W-1:0] i_row_index,
    input  logic [CENTROID_W-1:0]  i_centroid,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int SUM_W = 2 * COL_W - 1;
    localparam int LEN_W = COL_W + 1;
    localparam int QUO_W = SUM_W + FRAC_BITS;

    typedef struct {
        logic [ROW_INDEX_W-1:0] row;
        logic [CENTROID_W-1:0]  centroid;
    } t_row_centroid;

    t_row_centroid centroids_due[$];

    logic [COL_W-1:0]       column;
    logic [ROW_INDEX_W-1:0] row;
    t_phase                 phase;
    logic [SUM_W-1:0]       pos_sum;
    logic [LEN_W-1:0]       run_len;

    task automatic clear_row_scan();
        column  = '0;
        phase   = PH_BEFORE;
        pos_sum = '0;
        run_len = '0;
    endtask

    // Advances the row scan by one pixel and queues the centroid on a row end.
    task automatic scan_pixel(input logic [PIXEL_W-1:0] px, input logic last,
                              input logic first);
        logic          lit;
        logic [QUO_W-1:0] scaled;
        t_row_centroid mean;
        lit = (px != '0);
        if (first) begin
            clear_row_scan();
            row = '0;
        end
        case (phase)
            PH_BEFORE: begin
                if (lit) begin
                    phase   = PH_IN;
                    pos_sum = pos_sum + column;
                    run_len = run_len + 1'b1;
                end
            end
            PH_IN: begin
                if (lit) begin
                    pos_sum = pos_sum + column;
                    run_len = run_len + 1'b1;
                end else begin
                    phase = PH_AFTER;
                end
            end
            default: ;
        endcase
        if (last) begin
            scaled = QUO_W'(pos_sum);
            scaled = scaled << FRAC_BITS;
            mean.row = row;
            mean.centroid = (run_len == '0) ? '0 : CENTROID_W'(scaled / run_len);
            centroids_due.push_back(mean);
            clear_row_scan();
            row = (row >= MAX_ROWS - 1) ? '0 : row + 1'b1;
        end else if (column >= MAX_COLS - 1) begin
            column = COL_W'(MAX_COLS - 1);
            phase  = PH_AFTER;
        end else begin
            column = column + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_row_centroid want;
        if (!i_rst_n) begin
            clear_row_scan();
            row = '0;
            centroids_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_px_valid && !i_px_stall) begin
                scan_pixel(i_pixel, i_row_end, i_frame_start);
            end
            if (i_res_valid && !i_res_stall) begin
                if (centroids_due.size() == 0) begin
                    $display("%0t: unexpected word: row %0d centroid %0d", $time,
                             i_row_index, i_centroid);
                    o_fail_count++;
                end else begin
                    want = centroids_due.pop_front();
                    if (i_row_index !== want.row) begin
                        $display("%0t: row index expected %0d, got %0d", $time,
                                 want.row, i_row_index);
                        o_fail_count++;
                    end
                    if (i_centroid !== want.centroid) begin
                        $display("%0t: centroid of row %0d expected %0d, got %0d", $time,
                                 want.row, want.centroid, i_centroid);
                        o_fail_count++;
                    end
                    o_checked++;
                end
            end
        end
        o_pending = centroids_due.size();
    end

endmodule

@@ tb/row_first_run_centroid_tb.sv @@
// Top of the testbench for the row first-run centroid block: clock, reset, pixel stimulus,
// random stalls on the result side and the verdict.
// Depends on rfrc_pkg, row_first_run_centroid and row_centroid_checker.
`timescale 1ns / 1ps

module row_first_run_centroid_tb;
    import rfrc_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [PIXEL_W-1:0]     i_pixel = '0;
    logic                   i_row_end = 1'b0;
    logic                   i_frame_start = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [ROW_INDEX_W-1:0] o_row_index;
    logic [CENTROID_W-1:0]  o_centroid;

    int fail_count;
    int words_due;
    int words_checked;

    int send_gap_pct = 0;
    int hold_pct = 0;
    int pixels_sent = 0;
    int rows_sent = 0;

    always #1 i_clk = ~i_clk;

    row_first_run_centroid dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_row_end     (i_row_end),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_row_index   (o_row_index),
        .o_centroid    (o_centroid)
    );

    row_centroid_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px_valid    (i_valid),
        .i_px_stall    (o_stall),
        .i_pixel       (i_pixel),
        .i_row_end     (i_row_end),
        .i_frame_start (i_frame_start),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_row_index   (o_row_index),
        .i_centroid    (o_centroid),
        .o_fail_count  (fail_count),
        .o_pending     (words_due),
        .o_checked     (words_checked)
    );

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < hold_pct);
    end

    // Entered and left just after a falling edge; valid stays high on return so that
    // the next word can follow without a gap.
    task automatic put_word(input logic [PIXEL_W-1:0] px, input logic last,
                            input logic first);
        bit taken;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_row_end     <= last;
        i_frame_start <= first;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            @(negedge i_clk);
        end
        pixels_sent++;
        if (last) begin
            rows_sent++;
        end
    endtask

    // Mostly a background lead, one run and later runs that must be ignored;
    // some rows are plain noise.
    task automatic send_row(input int len, input bit new_frame);
        int lead;
        int run;
        int k;
        bit noisy;
        logic [PIXEL_W-1:0] px;
        noisy = ($urandom_range(0, 4) == 0);
        lead  = $urandom_range(0, len - 1);
        run   = $urandom_range(0, len - lead);
        for (k = 0; k < len; k++) begin
            if (noisy) begin
                px = $urandom_range(0, 1) ? PIXEL_W'($urandom_range(1, 255)) : '0;
            end else if (k >= lead && k < lead + run) begin
                px = PIXEL_W'($urandom_range(1, 255));
            end else if (k > lead + run && $urandom_range(0, 3) == 0) begin
                px = PIXEL_W'($urandom_range(1, 255));
            end else begin
                px = '0;
            end
            put_word(px, k == len - 1, (k == 0 && new_frame) || $urandom_range(0, 99) == 0);
        end
    endtask

    initial begin
        int mode;
        int target;
        int len;
        int drain_cycles;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-pixel rows at a frame start, lit and dark.
        put_word(8'hFF, 1'b1, 1'b1);
        put_word(8'h00, 1'b1, 1'b1);
        // A first run over columns 1 to 3 and a second run that must not count.
        put_word(8'h00, 1'b0, 1'b1);
        put_word(8'h01, 1'b0, 1'b0);
        put_word(8'h80, 1'b0, 1'b0);
        put_word(8'hFF, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'h55, 1'b0, 1'b0);
        put_word(8'hAA, 1'b1, 1'b0);
        // The run starts on the row's last pixel.
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'h7F, 1'b1, 1'b0);
        // The run covers the whole row from column 0.
        put_word(8'hFE, 1'b0, 1'b0);
        put_word(8'hFE, 1'b0, 1'b0);
        put_word(8'h01, 1'b1, 1'b0);
        // A frame start part way along a row restarts it as row 0.
        put_word(8'h10, 1'b0, 1'b0);
        put_word(8'h20, 1'b0, 1'b0);
        put_word(8'h40, 1'b0, 1'b1);
        put_word(8'h00, 1'b1, 1'b0);

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct = 31;
                    hold_pct     = 69;
                end
                1: begin
                    send_gap_pct = 69;
                    hold_pct     = 31;
                end
                default: begin
                    send_gap_pct = 0;
                    hold_pct     = 0;
                end
            endcase
            target = pixels_sent + 577;
            while (pixels_sent < target) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 40);
                send_row(len, $urandom_range(0, 9) == 0);
            end
        end
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (words_due != 0 && drain_cycles < 200000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (64) @(negedge i_clk);

        $display("Sent %0d pixels in %0d rows, with short and long rows, stray frame starts",
                 pixels_sent, rows_sent);
        $display("and stalls on both sides; checked %0d centroid words, %0d still outstanding.",
                 words_checked, words_due);
        if (fail_count == 0 && words_due == 0) begin
            $display("row_first_run_centroid: match");
        end else begin
            $display("row_first_run_centroid: mismatch");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Timed out with %0d centroid words outstanding.", words_due);
        $display("row_first_run_centroid: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rfrc_pkg.sv
rtl/rfrc_ctrl.sv
rtl/rfrc_dpath.sv
rtl/row_first_run_centroid.sv
tb/row_centroid_checker.sv
tb/row_first_run_centroid_tb.sv
